FILE: sv/hmmfwd_pkg.sv
// Shared types, codes and the control program of the HMM forward-pass unit.
package hmmfwd_pkg;

    localparam int OUT_W      = 32;
    localparam int PC_W       = 5;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    localparam logic [2:0] REG_TRANS0 = 3'd0;
    localparam logic [2:0] REG_TRANS1 = 3'd1;
    localparam logic [2:0] REG_EMIT0  = 3'd2;
    localparam logic [2:0] REG_EMIT1  = 3'd3;
    localparam logic [2:0] REG_INIT   = 3'd4;

    localparam logic [31:0] TRANS0_RST = 32'd1288549171;
    localparam logic [31:0] TRANS1_RST = 32'd2577032806;
    localparam logic [47:0] EMIT0_RST  = 48'd140739206322586;
    localparam logic [47:0] EMIT1_RST  = 48'd28150074684211;
    localparam logic [31:0] INIT_RST   = 32'd1718000026;

    localparam logic [1:0] SYM_INVALID = 2'd3;

    localparam logic [1:0] MUL_NONE = 2'd0;
    localparam logic [1:0] MUL_LO   = 2'd1;
    localparam logic [1:0] MUL_HI   = 2'd2;

    localparam logic [1:0] A_F0   = 2'd0;
    localparam logic [1:0] A_F1   = 2'd1;
    localparam logic [1:0] A_S    = 2'd2;
    localparam logic [1:0] A_INIT = 2'd3;

    localparam logic [1:0] P_T0   = 2'd0;
    localparam logic [1:0] P_T1   = 2'd1;
    localparam logic [1:0] P_EMIT = 2'd2;

    localparam logic [2:0] WR_NONE = 3'd0;
    localparam logic [2:0] WR_M0   = 3'd1;
    localparam logic [2:0] WR_S    = 3'd2;
    localparam logic [2:0] WR_NV   = 3'd3;
    localparam logic [2:0] WR_NVF  = 3'd4;

    localparam logic JMP_NEXT  = 1'b0;
    localparam logic JMP_FIRST = 1'b1;

    localparam logic [PC_W-1:0] UA_START = 5'd0;
    localparam logic [PC_W-1:0] UA_FIRST = 5'd14;

    typedef struct packed {
        logic [1:0]      mul;
        logic [1:0]      asel;
        logic [1:0]      psel;
        logic            mst;
        logic [2:0]      wr;
        logic            wst;
        logic            jmp;
        logic [PC_W-1:0] target;
        logic            done;
    } t_uword;

    typedef struct packed {
        logic   en;
        t_uword uw;
    } t_dp_ctrl;

    function automatic t_uword uw(
        input logic [1:0]      mul,
        input logic [1:0]      asel,
        input logic [1:0]      psel,
        input logic            mst,
        input logic [2:0]      wr,
        input logic            wst,
        input logic            jmp,
        input logic [PC_W-1:0] target,
        input logic            done
    );
        t_uword w;
        w.mul    = mul;
        w.asel   = asel;
        w.psel   = psel;
        w.mst    = mst;
        w.wr     = wr;
        w.wst    = wst;
        w.jmp    = jmp;
        w.target = target;
        w.done   = done;
        return w;
    endfunction

    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            5'd0:  w = uw(MUL_LO,   A_F0,   P_T0,   1'b0, WR_NONE, 1'b0, JMP_FIRST,
                          UA_FIRST, 1'b0);
            5'd1:  w = uw(MUL_HI,   A_F0,   P_T0,   1'b0, WR_NONE, 1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd2:  w = uw(MUL_LO,   A_F1,   P_T1,   1'b0, WR_M0,   1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd3:  w = uw(MUL_HI,   A_F1,   P_T1,   1'b0, WR_NONE, 1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd4:  w = uw(MUL_LO,   A_F0,   P_T0,   1'b1, WR_S,    1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd5:  w = uw(MUL_HI,   A_F0,   P_T0,   1'b1, WR_NONE, 1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd6:  w = uw(MUL_LO,   A_S,    P_EMIT, 1'b0, WR_M0,   1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd7:  w = uw(MUL_HI,   A_S,    P_EMIT, 1'b0, WR_NONE, 1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd8:  w = uw(MUL_LO,   A_F1,   P_T1,   1'b1, WR_NV,   1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd9:  w = uw(MUL_HI,   A_F1,   P_T1,   1'b1, WR_NONE, 1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd10: w = uw(MUL_NONE, A_F0,   P_T0,   1'b0, WR_S,    1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd11: w = uw(MUL_LO,   A_S,    P_EMIT, 1'b1, WR_NONE, 1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd12: w = uw(MUL_HI,   A_S,    P_EMIT, 1'b1, WR_NONE, 1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd13: w = uw(MUL_NONE, A_F0,   P_T0,   1'b0, WR_NV,   1'b1, JMP_NEXT,
                          UA_START, 1'b1);
            5'd14: w = uw(MUL_LO,   A_INIT, P_EMIT, 1'b0, WR_NONE, 1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd15: w = uw(MUL_HI,   A_INIT, P_EMIT, 1'b0, WR_NONE, 1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd16: w = uw(MUL_LO,   A_INIT, P_EMIT, 1'b1, WR_NVF,  1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd17: w = uw(MUL_HI,   A_INIT, P_EMIT, 1'b1, WR_NONE, 1'b0, JMP_NEXT,
                          UA_START, 1'b0);
            5'd18: w = uw(MUL_NONE, A_F0,   P_T0,   1'b0, WR_NVF,  1'b1, JMP_NEXT,
                          UA_START, 1'b1);
            default: w = uw(MUL_NONE, A_F0, P_T0,   1'b0, WR_NONE, 1'b0, JMP_NEXT,
                          UA_START, 1'b1);
        endcase
        return w;
    endfunction

endpackage

FILE: sv/hmmfwd_cfg_regs.sv
// APB-style register file holding the model probabilities.
module hmmfwd_cfg_regs import hmmfwd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [31:0]           o_trans_from0,
    output logic [31:0]           o_trans_from1,
    output logic [47:0]           o_emit_state0,
    output logic [47:0]           o_emit_state1,
    output logic [31:0]           o_init_probs
);

    logic [31:0] r_trans0;
    logic [31:0] r_trans1;
    logic [47:0] r_emit0;
    logic [47:0] r_emit1;
    logic [31:0] r_init;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans0 <= TRANS0_RST;
            r_trans1 <= TRANS1_RST;
            r_emit0  <= EMIT0_RST;
            r_emit1  <= EMIT1_RST;
            r_init   <= INIT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TRANS0: r_trans0 <= pwdata[31:0];
                REG_TRANS1: r_trans1 <= pwdata[31:0];
                REG_EMIT0:  r_emit0  <= pwdata[47:0];
                REG_EMIT1:  r_emit1  <= pwdata[47:0];
                REG_INIT:   r_init   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TRANS0: prdata = CFG_DATA_W'(r_trans0);
            REG_TRANS1: prdata = CFG_DATA_W'(r_trans1);
            REG_EMIT0:  prdata = CFG_DATA_W'(r_emit0);
            REG_EMIT1:  prdata = CFG_DATA_W'(r_emit1);
            REG_INIT:   prdata = CFG_DATA_W'(r_init);
            default:    prdata = '0;
        endcase
    end

    assign o_trans_from0 = r_trans0;
    assign o_trans_from1 = r_trans1;
    assign o_emit_state0 = r_emit0;
    assign o_emit_state1 = r_emit1;
    assign o_init_probs  = r_init;

endmodule

FILE: sv/hmmfwd_seq.sv
// Microcode sequencer: step counter, control ROM fetch and first-symbol branch.
module hmmfwd_seq import hmmfwd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_first,
    input  logic     i_out_free,
    output logic     o_busy,
    output t_dp_ctrl o_ctrl
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            r_busy;
    logic            r_first;
    t_uword          word;
    logic            fire;

    assign word = ucode_rom(r_pc);
    assign fire = r_busy && !(word.done && !i_out_free);

    always_comb begin
        n_pc = r_pc;
        if (i_start) begin
            n_pc = UA_START;
        end else if (fire) begin
            if (word.jmp == JMP_FIRST && r_first) begin
                n_pc = word.target;
            end else begin
                n_pc = r_pc + PC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= UA_START;
            r_busy  <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_first <= i_first;
            end else if (fire && word.done) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy    = r_busy;
    assign o_ctrl.en = fire;
    assign o_ctrl.uw = word;

endmodule

FILE: sv/hmmfwd_datapath.sv
// Shared multiplier, accumulator, forward-value registers and result registers.
module hmmfwd_datapath import hmmfwd_pkg::*; #(
    parameter int PROB_BITS = 16,
    parameter int FWD_BITS  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_symbol,
    input  logic             i_last,
    input  t_dp_ctrl         i_ctrl,
    input  logic [31:0]      i_trans_from0,
    input  logic [31:0]      i_trans_from1,
    input  logic [47:0]      i_emit_state0,
    input  logic [47:0]      i_emit_state1,
    input  logic [31:0]      i_init_probs,
    output logic [OUT_W-1:0] o_forward0,
    output logic [OUT_W-1:0] o_forward1,
    output logic [OUT_W-1:0] o_seq_prob,
    output logic             o_last_out
);

    localparam int XW  = (FWD_BITS > PROB_BITS) ? FWD_BITS : PROB_BITS;
    localparam int HW  = (XW + 1) / 2;
    localparam int LW  = XW - HW;
    localparam int AW  = XW + PROB_BITS;
    localparam int RW  = (3 * PROB_BITS > 48) ? 3 * PROB_BITS : 48;
    localparam int SHL = (FWD_BITS >= 2 * PROB_BITS) ? FWD_BITS - 2 * PROB_BITS : 0;
    localparam int SHR = (FWD_BITS >= 2 * PROB_BITS) ? 0 : 2 * PROB_BITS - FWD_BITS;

    function automatic logic [PROB_BITS-1:0] pfield(input logic [RW-1:0] r,
                                                    input logic [1:0] k);
        return r[k*PROB_BITS +: PROB_BITS];
    endfunction

    function automatic logic [FWD_BITS-1:0] sat_add(input logic [FWD_BITS-1:0] a,
                                                    input logic [FWD_BITS-1:0] b);
        logic [FWD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[FWD_BITS] ? {FWD_BITS{1'b1}} : s[FWD_BITS-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [FWD_BITS-1:0] x);
        logic [FWD_BITS+OUT_W-1:0] t;
        t = (FWD_BITS + OUT_W)'(x);
        return t[OUT_W-1:0];
    endfunction

    t_uword                    w;
    logic [RW-1:0]             t0_ext;
    logic [RW-1:0]             t1_ext;
    logic [RW-1:0]             e0_ext;
    logic [RW-1:0]             e1_ext;
    logic [RW-1:0]             init_ext;
    logic [1:0]                sidx;
    logic [PROB_BITS-1:0]      emis;
    logic [XW-1:0]             a_op;
    logic [PROB_BITS-1:0]      p_op;
    logic [HW+PROB_BITS-1:0]   prod_lo;
    logic [LW+PROB_BITS-1:0]   prod_hi;
    logic [AW-1:0]             n_acc;
    logic [XW-1:0]             sh;
    logic [FWD_BITS-1:0]       sh_f;
    logic [AW+SHL-1:0]         fs_wide;
    logic [AW+SHL-1:0]         fs;
    logic [FWD_BITS-1:0]       wval;
    logic [FWD_BITS-1:0]       n_nv [2];
    logic [FWD_BITS-1:0]       sum_nv;

    logic [AW-1:0]             r_acc;
    logic [FWD_BITS-1:0]       r_m0;
    logic [FWD_BITS-1:0]       r_s;
    logic [FWD_BITS-1:0]       r_nv [2];
    logic [FWD_BITS-1:0]       r_fwd [2];
    logic [1:0]                r_sym;
    logic                      r_last;
    logic [OUT_W-1:0]          r_out_f0;
    logic [OUT_W-1:0]          r_out_f1;
    logic [OUT_W-1:0]          r_out_sum;
    logic                      r_out_last;

    assign w        = i_ctrl.uw;
    assign t0_ext   = RW'(i_trans_from0);
    assign t1_ext   = RW'(i_trans_from1);
    assign e0_ext   = RW'(i_emit_state0);
    assign e1_ext   = RW'(i_emit_state1);
    assign init_ext = RW'(i_init_probs);
    assign sidx     = {1'b0, w.mst};

    always_comb begin
        if (r_sym == SYM_INVALID) begin
            emis = '0;
        end else if (w.mst) begin
            emis = pfield(e1_ext, r_sym);
        end else begin
            emis = pfield(e0_ext, r_sym);
        end
    end

    always_comb begin
        case (w.asel)
            A_F0:    a_op = XW'(r_fwd[0]);
            A_F1:    a_op = XW'(r_fwd[1]);
            A_S:     a_op = XW'(r_s);
            A_INIT:  a_op = XW'(pfield(init_ext, sidx));
            default: a_op = '0;
        endcase
    end

    always_comb begin
        case (w.psel)
            P_T0:    p_op = pfield(t0_ext, sidx);
            P_T1:    p_op = pfield(t1_ext, sidx);
            P_EMIT:  p_op = emis;
            default: p_op = '0;
        endcase
    end

    assign prod_lo = (HW + PROB_BITS)'(a_op[HW-1:0]) * (HW + PROB_BITS)'(p_op);
    assign prod_hi = (LW + PROB_BITS)'(a_op[XW-1:HW]) * (LW + PROB_BITS)'(p_op);

    always_comb begin
        case (w.mul)
            MUL_LO:  n_acc = AW'(prod_lo);
            MUL_HI:  n_acc = r_acc + (AW'(prod_hi) << HW);
            default: n_acc = r_acc;
        endcase
    end

    assign sh   = r_acc[AW-1:PROB_BITS];
    assign sh_f = (sh > XW'({FWD_BITS{1'b1}})) ? {FWD_BITS{1'b1}} : sh[FWD_BITS-1:0];

    assign fs_wide = (AW + SHL)'(r_acc) << SHL;
    assign fs      = fs_wide >> SHR;

    assign wval = (w.wr == WR_NVF) ? fs[FWD_BITS-1:0] : sh_f;

    always_comb begin
        n_nv[0] = r_nv[0];
        n_nv[1] = r_nv[1];
        if (w.wr == WR_NV || w.wr == WR_NVF) begin
            n_nv[w.wst] = wval;
        end
    end

    assign sum_nv = sat_add(n_nv[0], n_nv[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd[0] <= '0;
            r_fwd[1] <= '0;
        end else if (i_ctrl.en && w.done) begin
            r_fwd[0] <= n_nv[0];
            r_fwd[1] <= n_nv[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sym  <= i_symbol;
            r_last <= i_last;
        end
        if (i_ctrl.en) begin
            r_acc   <= n_acc;
            r_nv[0] <= n_nv[0];
            r_nv[1] <= n_nv[1];
            if (w.wr == WR_M0) begin
                r_m0 <= sh_f;
            end
            if (w.wr == WR_S) begin
                r_s <= sat_add(r_m0, sh_f);
            end
            if (w.done) begin
                r_out_f0   <= to_out(n_nv[0]);
                r_out_f1   <= to_out(n_nv[1]);
                r_out_sum  <= to_out(sum_nv);
                r_out_last <= r_last;
            end
        end
    end

    assign o_forward0 = r_out_f0;
    assign o_forward1 = r_out_f1;
    assign o_seq_prob = r_out_sum;
    assign o_last_out = r_out_last;

endmodule

FILE: sv/hmm_forward_alpha_pass_unit.sv
// Top level of the two-state, three-symbol HMM forward-pass unit.
//
// Input channel (i_in_valid / o_in_stall) carries one observed symbol per item
// with its first and last flags. Output channel (o_out_valid / i_out_stall)
// carries one result per item: both forward values, their saturated sum and
// the echoed last flag. Model probabilities sit in five registers on the
// APB-style port at byte addresses 0, 8, 16, 24 and 32.
// A small control program in ROM steps one shared multiplier through the
// recursion, at most one partial product per cycle:
//   first symbol of a sequence: initial times emission probability per state,
//   later symbols: six products of two halves each.
// One item is worked on at a time; o_in_stall is high while it runs, so a
// new item is taken the cycle after the result is loaded. A waiting result
// does not block the next item; only the final step holds while the output
// register is still full and stalled.
// Reset clears the forward values to zero, loads the default model
// probabilities and empties the output register.
module hmm_forward_alpha_pass_unit import hmmfwd_pkg::*; #(
    parameter int PROB_BITS = 16,
    parameter int FWD_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_symbol,
    input  logic                  i_first,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [OUT_W-1:0]      o_forward0,
    output logic [OUT_W-1:0]      o_forward1,
    output logic [OUT_W-1:0]      o_seq_prob,
    output logic                  o_last_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic        busy;
    logic        start;
    logic        out_free;
    logic        r_out_valid;
    t_dp_ctrl    ctrl;
    logic [31:0] trans_from0;
    logic [31:0] trans_from1;
    logic [47:0] emit_state0;
    logic [47:0] emit_state1;
    logic [31:0] init_probs;

    assign start    = i_in_valid && !busy;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.en && ctrl.uw.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    hmmfwd_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_trans_from0 (trans_from0),
        .o_trans_from1 (trans_from1),
        .o_emit_state0 (emit_state0),
        .o_emit_state1 (emit_state1),
        .o_init_probs  (init_probs)
    );

    hmmfwd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_first    (i_first),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_ctrl     (ctrl)
    );

    hmmfwd_datapath #(
        .PROB_BITS (PROB_BITS),
        .FWD_BITS  (FWD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_symbol      (i_symbol),
        .i_last        (i_last),
        .i_ctrl        (ctrl),
        .i_trans_from0 (trans_from0),
        .i_trans_from1 (trans_from1),
        .i_emit_state0 (emit_state0),
        .i_emit_state1 (emit_state1),
        .i_init_probs  (init_probs),
        .o_forward0    (o_forward0),
        .o_forward1    (o_forward1),
        .o_seq_prob    (o_seq_prob),
        .o_last_out    (o_last_out)
    );

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;

endmodule
